// ===== hw/rtl/sed_pkg.sv =====
// Shared types, character codes and status codes for the string escape decoder.
// Used by the decoder top level and by its port checker; depends on nothing.
package sed_pkg;

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_ESC    = 3'd1,
      MODE_HEX1   = 3'd2,
      MODE_HEX2   = 3'd3,
      MODE_SKIP   = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_UNDEF_ESC = 2'd1,
      STATUS_HEX_RANGE = 2'd2
   } status_type;

   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_X      = 8'h78;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_SEVEN  = 8'h37;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_LF     = 8'h0A;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_digit_type;

   // Decodes one hex digit character; ok is low for anything else.
   function automatic hex_digit_type hex_low_digit(input logic [7:0] c);
      hex_digit_type d;
      d.ok    = 1'b1;
      d.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d.value = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         d.value = c[3:0] + 4'd9;
      end else begin
         d.ok = 1'b0;
      end
      return d;
   endfunction

endpackage

// ===== hw/rtl/string_escape_decoder_top.sv =====
// String escape decoder: accepts one byte per cycle while the consumer does not stall.
// An input register holds each accepted byte and feeds the escape decode logic,
// whose outcome lands in a result register that holds while the consumer stalls.
// Synchronous active-high reset empties both registers and returns to normal mode.
// Depends on sed_pkg.
module string_escape_decoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_has_byte,
   output logic [1:0] rsp_status,
   output logic       rsp_done_res
);
   import sed_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   mode_type   mode_ff, mode_in;
   logic [3:0] hex_hi_ff, hex_hi_in;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_has_ff, out_has_in;
   status_type out_status_ff, out_status_in;
   logic       out_done_ff, out_done_in;

   logic       out_free;
   logic       advance;
   logic       emit;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   // Escape decode for the byte in the input register.
   always_comb begin
      hex_digit_type lo;
      lo          = hex_low_digit(in_byte_ff);
      mode_in     = mode_ff;
      hex_hi_in   = hex_hi_ff;
      emit        = 1'b0;
      out_byte_in = 8'd0;
      out_has_in  = 1'b0;
      out_status_in = STATUS_OK;
      out_done_in = in_last_ff;

      case (mode_ff)
         MODE_SKIP: begin
            if (in_last_ff) begin
               mode_in = MODE_NORMAL;
            end
         end
         MODE_ESC: begin
            mode_in = MODE_NORMAL;
            emit    = 1'b1;
            case (in_byte_ff)
               CHAR_R: begin
                  out_byte_in = CHAR_CR;
                  out_has_in  = 1'b1;
               end
               CHAR_T: begin
                  out_byte_in = CHAR_TAB;
                  out_has_in  = 1'b1;
               end
               CHAR_N: begin
                  out_byte_in = CHAR_LF;
                  out_has_in  = 1'b1;
               end
               CHAR_DQUOTE, CHAR_BSLASH: begin
                  out_byte_in = in_byte_ff;
                  out_has_in  = 1'b1;
               end
               CHAR_ZERO: begin
                  out_done_in = 1'b1;
                  mode_in     = in_last_ff ? MODE_NORMAL : MODE_SKIP;
                  hex_hi_in   = 4'd0;
               end
               CHAR_X: begin
                  if (in_last_ff) begin
                     out_status_in = STATUS_UNDEF_ESC;
                     out_done_in   = 1'b1;
                     hex_hi_in     = 4'd0;
                  end else begin
                     emit    = 1'b0;
                     mode_in = MODE_HEX1;
                  end
               end
               default: begin
                  out_status_in = STATUS_UNDEF_ESC;
                  out_done_in   = 1'b1;
                  mode_in       = in_last_ff ? MODE_NORMAL : MODE_SKIP;
                  hex_hi_in     = 4'd0;
               end
            endcase
         end
         MODE_HEX1: begin
            if (in_last_ff) begin
               // An escape cut off by the end of the string.
               emit          = 1'b1;
               out_status_in = STATUS_UNDEF_ESC;
               out_done_in   = 1'b1;
               mode_in       = MODE_NORMAL;
               hex_hi_in     = 4'd0;
            end else begin
               mode_in   = MODE_HEX2;
               hex_hi_in = (in_byte_ff > CHAR_ZERO && in_byte_ff < CHAR_SEVEN) ?
                           in_byte_ff[3:0] : 4'd0;
            end
         end
         MODE_HEX2: begin
            emit      = 1'b1;
            hex_hi_in = 4'd0;
            if (hex_hi_ff == 4'd0 || !lo.ok) begin
               out_status_in = STATUS_HEX_RANGE;
               out_done_in   = 1'b1;
               mode_in       = in_last_ff ? MODE_NORMAL : MODE_SKIP;
            end else begin
               mode_in     = MODE_NORMAL;
               out_byte_in = {hex_hi_ff, lo.value};
               out_has_in  = 1'b1;
            end
         end
         default: begin
            mode_in = MODE_NORMAL;
            if (in_byte_ff == CHAR_BSLASH) begin
               if (in_last_ff) begin
                  emit          = 1'b1;
                  out_status_in = STATUS_UNDEF_ESC;
                  out_done_in   = 1'b1;
                  hex_hi_in     = 4'd0;
               end else begin
                  mode_in = MODE_ESC;
               end
            end else begin
               emit        = 1'b1;
               out_byte_in = in_byte_ff;
               out_has_in  = 1'b1;
            end
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = advance && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= MODE_NORMAL;
         hex_hi_ff    <= 4'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            mode_ff   <= mode_in;
            hex_hi_ff <= hex_hi_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_last_byte;
      end
      if (advance && emit) begin
         out_byte_ff   <= out_byte_in;
         out_has_ff    <= out_has_in;
         out_status_ff <= out_status_in;
         out_done_ff   <= out_done_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_has_byte = out_has_ff;
   assign rsp_status   = out_status_ff;
   assign rsp_done_res = out_done_ff;

endmodule

// ===== hw/rtl/sed_checker.sv =====
// Port-level checker for the string escape decoder, bound to the top level.
// Depends on sed_pkg and string_escape_decoder_top.
module sed_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_has_byte,
   input logic [1:0] rsp_status,
   input logic       rsp_done_res
);
   import sed_pkg::*;

   // Every error result ends the string and carries no byte.
   a_error_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> rsp_done_res && !rsp_has_byte)
      else $error("error item does not end the string");

   // A result either carries a byte or ends the string.
   a_no_empty_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_has_byte || rsp_done_res)
      else $error("empty result item");

   // An item without a byte shows zero in the byte field.
   a_zero_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_byte |-> rsp_out_byte == 8'd0)
      else $error("byte field not zero");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STATUS_OK || rsp_status == STATUS_UNDEF_ESC ||
                    rsp_status == STATUS_HEX_RANGE)
      else $error("unknown status code");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) &&
                                 $stable(rsp_status) && $stable(rsp_done_res))
      else $error("stalled item changed");

endmodule

bind string_escape_decoder_top sed_checker u_sed_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_byte (rsp_out_byte),
   .rsp_has_byte (rsp_has_byte),
   .rsp_status   (rsp_status),
   .rsp_done_res (rsp_done_res)
);
